// File: hw/rtl/vocol_pkg.sv
// ----------------------------------------------------------------------------
// vocol_pkg: shared constants for the velocity-obstacle collision test
// Field widths, stream word layout, register map and reset values.
// ----------------------------------------------------------------------------
package vocol_pkg;

    // field widths
    localparam int unsigned COORD_W       = 24;   // signed Q16.8 coordinate
    localparam int unsigned RAD_W         = 20;   // unsigned Q12.8 radius
    localparam int unsigned HOR_W         = 16;   // unsigned Q8.8 seconds
    localparam int unsigned FRAC_BITS_DEF = 8;

    // shared multiplier: multiplier digit consumed per cycle
    localparam int unsigned MUL_DIG_W = 16;

    // input word layout, lowest bit first
    localparam int unsigned OFS_CAND_VX    = 0;
    localparam int unsigned OFS_CAND_VY    = OFS_CAND_VX + COORD_W;
    localparam int unsigned OFS_ACTOR_X    = OFS_CAND_VY + COORD_W;
    localparam int unsigned OFS_ACTOR_Y    = OFS_ACTOR_X + COORD_W;
    localparam int unsigned OFS_NBR_X      = OFS_ACTOR_Y + COORD_W;
    localparam int unsigned OFS_NBR_Y      = OFS_NBR_X + COORD_W;
    localparam int unsigned OFS_NBR_VX     = OFS_NBR_Y + COORD_W;
    localparam int unsigned OFS_NBR_VY     = OFS_NBR_VX + COORD_W;
    localparam int unsigned OFS_NBR_RADIUS = OFS_NBR_VY + COORD_W;
    localparam int unsigned S_FIELDS_W     = OFS_NBR_RADIUS + RAD_W;
    localparam int unsigned S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W      = 8;

    // configuration port
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_AGENT_RADIUS = 1'b0,
        REG_HORIZON      = 1'b1
    } t_reg_idx;

    localparam logic [RAD_W-1:0] AGENT_RADIUS_RST = '0;
    localparam logic [HOR_W-1:0] HORIZON_RST      = 16'd256;

endpackage

// File: hw/rtl/velocity_obstacle_collision_test.sv
// ----------------------------------------------------------------------------
// velocity_obstacle_collision_test
// Velocity-obstacle test of one candidate velocity against a run of neighbors.
// ----------------------------------------------------------------------------
// One neighbor word is taken at a time. A word that goes through the whole
// test occupies the block until its last product is consumed; a neighbor
// that is not approaching leaves after the dot product, and one with zero
// relative speed after the squared speed. The pace is set by the one shared
// 66 x 16 bit multiplier, which retires one 16-bit multiplier digit per cycle
// (11 products of 1 to 5 digits, each followed by a step that consumes the
// product). The verdict of a run is written to an output register when its
// last word finishes; that word waits only while an earlier verdict is still
// untaken. Hits are exact: all intermediate values are held at full width.

module velocity_obstacle_collision_test #(
    parameter int unsigned FRAC_BITS = vocol_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // neighbor words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cand_vx, cand_vy, actor_x, actor_y, nbr_x, nbr_y, nbr_vx, nbr_vy, nbr_radius
    input  logic [vocol_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,      // is_last
    // verdict words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [vocol_pkg::M_TDATA_W-1:0]     m_axis_tdata,      // forbidden
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vocol_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [vocol_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vocol_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import vocol_pkg::*;

    localparam int unsigned MD     = MUL_DIG_W;
    localparam int unsigned DW     = COORD_W + 1;             // coordinate difference
    localparam int unsigned SQW    = 2 * DW;                  // squares and dot products
    localparam int unsigned PVW    = SQW + 1;                 // signed dot product
    localparam int unsigned RW     = RAD_W + 1;               // combined radius
    localparam int unsigned R2W    = 2 * RW;
    localparam int unsigned DDW    = 2 * SQW;                 // discriminant
    localparam int unsigned LSH    = (FRAC_BITS > HOR_W) ? FRAC_BITS : HOR_W;
    localparam int unsigned LW     = SQW + LSH;               // horizon term
    localparam int unsigned OPW    = LW;                      // widest operand
    localparam int unsigned PW     = 2 * OPW;
    localparam int unsigned ND_MAX = (OPW + MD - 1) / MD;
    localparam int unsigned BW     = ND_MAX * MD;
    localparam int unsigned KW     = (ND_MAX > 1) ? $clog2(ND_MAX) : 1;
    localparam int unsigned ND_DIF = (DW + MD - 1) / MD;
    localparam int unsigned ND_RAD = (RW + MD - 1) / MD;
    localparam int unsigned ND_SQ  = (SQW + MD - 1) / MD;
    localparam int unsigned ND_HOR = (HOR_W + MD - 1) / MD;
    localparam int unsigned CMPW   = (2 * LW > DDW + 2 * FRAC_BITS) ?
                                     2 * LW : DDW + 2 * FRAC_BITS;

    localparam logic [KW-1:0] K_DIF = KW'(ND_DIF - 1);
    localparam logic [KW-1:0] K_RAD = KW'(ND_RAD - 1);
    localparam logic [KW-1:0] K_SQ  = KW'(ND_SQ - 1);
    localparam logic [KW-1:0] K_HOR = KW'(ND_HOR - 1);
    localparam logic [KW-1:0] K_MAG = KW'(ND_MAX - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_PXVX,
        OP_PYVY,
        OP_VXVX,
        OP_VYVY,
        OP_PXPX,
        OP_PYPY,
        OP_RR,
        OP_PVPV,
        OP_VVC,
        OP_HVV,
        OP_MAG
    } t_op;

    function automatic logic [KW-1:0] f_klast(input t_op op);
        logic [KW-1:0] k;
        unique case (op)
            OP_PXVX, OP_PYVY, OP_VXVX, OP_VYVY, OP_PXPX, OP_PYPY: k = K_DIF;
            OP_RR:            k = K_RAD;
            OP_PVPV, OP_VVC:  k = K_SQ;
            OP_HVV:           k = K_HOR;
            OP_MAG:           k = K_MAG;
            default:          k = K_MAG;
        endcase
        return k;
    endfunction

    function automatic t_op f_next_op(input t_op op);
        t_op n;
        unique case (op)
            OP_PXVX: n = OP_PYVY;
            OP_PYVY: n = OP_VXVX;
            OP_VXVX: n = OP_VYVY;
            OP_VYVY: n = OP_PXPX;
            OP_PXPX: n = OP_PYPY;
            OP_PYPY: n = OP_RR;
            OP_RR:   n = OP_PVPV;
            OP_PVPV: n = OP_VVC;
            OP_VVC:  n = OP_HVV;
            OP_HVV:  n = OP_MAG;
            OP_MAG:  n = OP_MAG;
            default: n = OP_MAG;
        endcase
        return n;
    endfunction

    // configuration registers
    logic [RAD_W-1:0] r_agent_radius;
    logic [HOR_W-1:0] r_horizon;
    logic             w_cfg_wr;
    t_reg_idx         w_reg_idx;

    // sequencer and datapath registers
    t_state                  r_state;
    t_op                     r_op;
    logic [KW-1:0]           r_k;
    logic [PW-1:0]           r_acc;
    logic [DW-1:0]           r_px_mag, r_py_mag, r_vx_mag, r_vy_mag;
    logic                    r_negx, r_negy;
    logic [RW-1:0]           r_rad;
    logic                    r_last;
    logic signed [PVW-1:0]   r_pv;
    logic [SQW-1:0]          r_vv, r_pp, r_cmag;
    logic                    r_c_pos;
    logic [DDW-1:0]          r_d;
    logic                    r_l_nonpos;
    logic [LW-1:0]           r_mag;
    logic                    r_hit, r_hit_seen;
    logic                    r_m_valid, r_m_forbidden;

    // input word fields
    logic signed [COORD_W-1:0] w_cand_vx, w_cand_vy, w_actor_x, w_actor_y;
    logic signed [COORD_W-1:0] w_nbr_x, w_nbr_y, w_nbr_vx, w_nbr_vy;
    logic [RAD_W-1:0]          w_nbr_radius;
    logic signed [DW-1:0]      n_px, n_py, n_vx, n_vy;
    logic [DW-1:0]             n_px_mag, n_py_mag, n_vx_mag, n_vy_mag;
    logic [RW-1:0]             n_rad;
    logic                      w_accept;

    // shared multiplier
    logic [OPW-1:0]      w_ma;
    logic [BW-1:0]       w_mb;
    logic [MD-1:0]       w_dig;
    logic [OPW+MD-1:0]   n_prod;
    logic [PW-1:0]       n_acc;

    // product consumers
    logic [SQW-1:0]        w_prod_sq;
    logic signed [PVW-1:0] w_term_pos, n_term, n_pv_sum;
    logic                  w_term_neg, w_pv_nonpos;
    logic [SQW-1:0]        n_vv_sum, n_pp_sum;
    logic [SQW-1:0]        w_r2;
    logic                  n_c_pos;
    logic [SQW-1:0]        n_cmag;
    logic [DDW-1:0]        w_vc, n_d_new;
    logic                  w_d_neg;
    logic [LW-1:0]         w_a, w_b, n_mag;
    logic                  n_l_nonpos;
    logic [CMPW-1:0]       w_lhs, w_rhs;
    logic                  n_hit, w_hit_total, w_out_free;
    logic                  w_post_stop, w_emit;
    t_op                   n_next_op;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2:2]);
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agent_radius <= AGENT_RADIUS_RST;
            r_horizon      <= HORIZON_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_AGENT_RADIUS: r_agent_radius <= pwdata[RAD_W-1:0];
                REG_HORIZON:      r_horizon      <= pwdata[HOR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_AGENT_RADIUS: prdata = CFG_DATA_W'(r_agent_radius);
            REG_HORIZON:      prdata = CFG_DATA_W'(r_horizon);
        endcase
    end

    // ---------------- input word ----------------
    assign w_cand_vx    = s_axis_tdata[OFS_CAND_VX +: COORD_W];
    assign w_cand_vy    = s_axis_tdata[OFS_CAND_VY +: COORD_W];
    assign w_actor_x    = s_axis_tdata[OFS_ACTOR_X +: COORD_W];
    assign w_actor_y    = s_axis_tdata[OFS_ACTOR_Y +: COORD_W];
    assign w_nbr_x      = s_axis_tdata[OFS_NBR_X +: COORD_W];
    assign w_nbr_y      = s_axis_tdata[OFS_NBR_Y +: COORD_W];
    assign w_nbr_vx     = s_axis_tdata[OFS_NBR_VX +: COORD_W];
    assign w_nbr_vy     = s_axis_tdata[OFS_NBR_VY +: COORD_W];
    assign w_nbr_radius = s_axis_tdata[OFS_NBR_RADIUS +: RAD_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    // relative position and velocity, split into magnitude and sign
    assign n_px = {w_nbr_x[COORD_W-1], w_nbr_x} - {w_actor_x[COORD_W-1], w_actor_x};
    assign n_py = {w_nbr_y[COORD_W-1], w_nbr_y} - {w_actor_y[COORD_W-1], w_actor_y};
    assign n_vx = {w_cand_vx[COORD_W-1], w_cand_vx} - {w_nbr_vx[COORD_W-1], w_nbr_vx};
    assign n_vy = {w_cand_vy[COORD_W-1], w_cand_vy} - {w_nbr_vy[COORD_W-1], w_nbr_vy};

    assign n_px_mag = n_px[DW-1] ? DW'(-n_px) : DW'(n_px);
    assign n_py_mag = n_py[DW-1] ? DW'(-n_py) : DW'(n_py);
    assign n_vx_mag = n_vx[DW-1] ? DW'(-n_vx) : DW'(n_vx);
    assign n_vy_mag = n_vy[DW-1] ? DW'(-n_vy) : DW'(n_vy);
    assign n_rad    = RW'(r_agent_radius) + RW'(w_nbr_radius);

    // ---------------- shared multiplier ----------------
    always_comb begin
        unique case (r_op)
            OP_PXVX: begin w_ma = OPW'(r_px_mag);  w_mb = BW'(r_vx_mag);  end
            OP_PYVY: begin w_ma = OPW'(r_py_mag);  w_mb = BW'(r_vy_mag);  end
            OP_VXVX: begin w_ma = OPW'(r_vx_mag);  w_mb = BW'(r_vx_mag);  end
            OP_VYVY: begin w_ma = OPW'(r_vy_mag);  w_mb = BW'(r_vy_mag);  end
            OP_PXPX: begin w_ma = OPW'(r_px_mag);  w_mb = BW'(r_px_mag);  end
            OP_PYPY: begin w_ma = OPW'(r_py_mag);  w_mb = BW'(r_py_mag);  end
            OP_RR:   begin w_ma = OPW'(r_rad);     w_mb = BW'(r_rad);     end
            OP_PVPV: begin
                w_ma = OPW'(r_pv[SQW-1:0]);
                w_mb = BW'(r_pv[SQW-1:0]);
            end
            OP_VVC:  begin w_ma = OPW'(r_vv);      w_mb = BW'(r_cmag);    end
            OP_HVV:  begin w_ma = OPW'(r_vv);      w_mb = BW'(r_horizon); end
            OP_MAG:  begin w_ma = OPW'(r_mag);     w_mb = BW'(r_mag);     end
            default: begin w_ma = '0;              w_mb = '0;             end
        endcase
    end

    // digits are taken from the top; acc = acc * 2^MD + A * digit
    assign w_dig  = w_mb[r_k * MD +: MD];
    assign n_prod = w_ma * w_dig;
    assign n_acc  = (r_acc << MD) + PW'(n_prod);

    // ---------------- product consumers ----------------
    assign w_prod_sq   = r_acc[SQW-1:0];
    assign w_term_neg  = (r_op == OP_PXVX) ? r_negx : r_negy;
    assign w_term_pos  = {1'b0, w_prod_sq};
    assign n_term      = w_term_neg ? -w_term_pos : w_term_pos;
    assign n_pv_sum    = r_pv + n_term;
    assign w_pv_nonpos = n_pv_sum[PVW-1] || (n_pv_sum == '0);
    assign n_vv_sum    = r_vv + w_prod_sq;
    assign n_pp_sum    = r_pp + w_prod_sq;

    // c = |p|^2 - R^2
    assign w_r2    = SQW'(r_acc[R2W-1:0]);
    assign n_c_pos = r_pp > w_r2;
    assign n_cmag  = n_c_pos ? (r_pp - w_r2) : (w_r2 - r_pp);

    // discriminant; r_d holds PV^2 at this point
    assign w_vc    = r_acc[DDW-1:0];
    assign w_d_neg = r_c_pos && (r_d < w_vc);
    assign n_d_new = r_c_pos ? (r_d - w_vc) : (r_d + w_vc);

    // L = 2^F * PV - h * VV
    assign w_b        = r_acc[LW-1:0];
    assign w_a        = LW'(r_pv[SQW-1:0]) << FRAC_BITS;
    assign n_l_nonpos = w_a <= w_b;
    assign n_mag      = n_l_nonpos ? (w_b - w_a) : (w_a - w_b);

    // L^2 against D * 2^2F; approaching from outside takes the earlier root
    assign w_lhs = CMPW'(r_acc);
    assign w_rhs = CMPW'(r_d) << (2 * FRAC_BITS);
    assign n_hit = r_c_pos ? (r_l_nonpos || (w_lhs <= w_rhs))
                           : (r_l_nonpos && (w_lhs >= w_rhs));

    assign n_next_op   = f_next_op(r_op);
    assign w_hit_total = r_hit_seen | r_hit;
    assign w_out_free  = !r_m_valid || m_axis_tready;
    assign w_emit      = (r_state == ST_DONE) && r_last && w_out_free;

    // early exits and the final compare end the word
    always_comb begin
        unique case (r_op)
            OP_PYVY: w_post_stop = w_pv_nonpos;
            OP_VYVY: w_post_stop = (n_vv_sum == '0);
            OP_VVC:  w_post_stop = w_d_neg;
            OP_MAG:  w_post_stop = 1'b1;
            default: w_post_stop = 1'b0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_op          <= OP_PXVX;
            r_k           <= '0;
            r_hit_seen    <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_m_valid <= w_emit || (r_m_valid && !m_axis_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_px_mag <= n_px_mag;
                        r_py_mag <= n_py_mag;
                        r_vx_mag <= n_vx_mag;
                        r_vy_mag <= n_vy_mag;
                        r_negx   <= n_px[DW-1] ^ n_vx[DW-1];
                        r_negy   <= n_py[DW-1] ^ n_vy[DW-1];
                        r_rad    <= n_rad;
                        r_last   <= s_axis_tlast;
                        r_acc    <= '0;
                        r_op     <= OP_PXVX;
                        r_k      <= f_klast(OP_PXVX);
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_acc <= n_acc;
                    if (r_k == '0) begin
                        r_state <= ST_POST;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                ST_POST: begin
                    // consume the product and start the next one
                    r_acc   <= '0;
                    r_op    <= n_next_op;
                    r_k     <= f_klast(n_next_op);
                    r_state <= w_post_stop ? ST_DONE : ST_MUL;
                    unique case (r_op)
                        OP_PXVX: r_pv <= n_term;
                        OP_PYVY: begin
                            r_pv <= n_pv_sum;
                            if (w_pv_nonpos) begin
                                r_hit <= 1'b0;
                            end
                        end
                        OP_VXVX: r_vv <= w_prod_sq;
                        OP_VYVY: begin
                            r_vv <= n_vv_sum;
                            if (n_vv_sum == '0) begin
                                r_hit <= 1'b0;
                            end
                        end
                        OP_PXPX: r_pp <= w_prod_sq;
                        OP_PYPY: r_pp <= n_pp_sum;
                        OP_RR: begin
                            r_c_pos <= n_c_pos;
                            r_cmag  <= n_cmag;
                        end
                        OP_PVPV: r_d <= r_acc[DDW-1:0];
                        OP_VVC: begin
                            r_d <= n_d_new;
                            if (w_d_neg) begin
                                r_hit <= 1'b0;
                            end
                        end
                        OP_HVV: begin
                            r_l_nonpos <= n_l_nonpos;
                            r_mag      <= n_mag;
                        end
                        OP_MAG: r_hit <= n_hit;
                        default: ;
                    endcase
                end
                ST_DONE: begin
                    if (!r_last) begin
                        r_hit_seen <= w_hit_total;
                        r_state    <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_m_forbidden <= w_hit_total;
                        r_hit_seen    <= 1'b0;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - 1){1'b0}}, r_m_forbidden};

`ifndef SYNTH
    // a taken word keeps the block busy: it is not ready in the cycle after
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after an accepted word");

    // digit index stays inside the current product's digit count
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_k <= f_klast(r_op)))
        else $error("multiplier digit index out of range");

    // a verdict appears only after a last word finished
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE && r_last))
        else $error("verdict without a finished last word");

    // delivering a verdict starts a fresh run
    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_last && w_out_free) |=> (!r_hit_seen && m_axis_tvalid))
        else $error("hit history not cleared after a verdict");
`endif

endmodule
